// File: sv/hmsc_pkg.sv
// ----------------------------------------------------------------------------
// hmsc_pkg
// Shared types, command codes and digit helpers for the settable HH:MM:SS
// clock.
// ----------------------------------------------------------------------------
package hmsc_pkg;

   // Field widths
   localparam int CmdW    = 2;
   localparam int KeyW    = 5;
   localparam int HourW   = 5;
   localparam int MinW    = 6;
   localparam int SecW    = 6;
   localparam int CursorW = 3;
   localparam int TickW   = 12;
   localparam int CsrIdxW = 1;

   // Register reset values
   localparam logic [TickW-1:0] TicksPerSecReset = TickW'(1000);
   localparam logic [TickW-1:0] BlinkOnReset     = TickW'(500);

   // Wrap limits
   localparam logic [6:0] HourLimit = 7'd24;
   localparam logic [6:0] MinLimit  = 7'd60;
   localparam logic [CursorW-1:0] CursorLast = CursorW'(5);

   // Key codes that carry a digit
   localparam logic [KeyW-1:0] KeyDigitFirst = KeyW'(1);
   localparam logic [KeyW-1:0] KeyDigitLast  = KeyW'(10);

   typedef enum logic [CmdW-1:0] {
      CMD_TICK = 2'd0,
      CMD_MODE = 2'd1,
      CMD_NEXT = 2'd2,
      CMD_KEY  = 2'd3
   } cmd_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TICKS_PER_SEC = 1'b0,
      CSR_BLINK_ON      = 1'b1
   } csr_idx_type;

   typedef enum logic [CursorW-1:0] {
      CUR_HOUR_TENS  = 3'd0,
      CUR_HOUR_UNITS = 3'd1,
      CUR_MIN_TENS   = 3'd2,
      CUR_MIN_UNITS  = 3'd3,
      CUR_SEC_TENS   = 3'd4,
      CUR_SEC_UNITS  = 3'd5
   } cursor_type;

   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic [KeyW-1:0] key_code;
   } hmsc_req_type;

   typedef struct packed {
      logic [HourW-1:0]   hours;
      logic [MinW-1:0]    minutes;
      logic [SecW-1:0]    seconds;
      logic               editing;
      logic [CursorW-1:0] cursor;
      logic               cursor_blank;
   } hmsc_rsp_type;

   typedef struct packed {
      logic [TickW-1:0] ticks_per_second;
      logic [TickW-1:0] blink_on_ticks;
   } hmsc_cfg_type;

   // Tens digit of a value below 64
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      priority if (v >= 6'd60) t = 3'd6;
      else if (v >= 6'd50)     t = 3'd5;
      else if (v >= 6'd40)     t = 3'd4;
      else if (v >= 6'd30)     t = 3'd3;
      else if (v >= 6'd20)     t = 3'd2;
      else if (v >= 6'd10)     t = 3'd1;
      else                     t = 3'd0;
      return t;
   endfunction

   // Replace the tens or units digit of v; keep v if the result reaches limit
   function automatic logic [5:0] set_digit(input logic [5:0] v,
                                            input logic [3:0] d,
                                            input logic       tens_pos,
                                            input logic [6:0] limit);
      logic [2:0] t;
      logic [3:0] u;
      logic [6:0] nv;
      t  = tens_of(v);
      u  = 4'(v - {3'b000, t} * 6'd10);
      nv = tens_pos ? (7'(u) + 7'(d) * 7'd10) : (7'(t) * 7'd10 + 7'(d));
      return (nv < limit) ? nv[5:0] : v;
   endfunction

endpackage

// File: sv/hmsc_csr.sv
// ----------------------------------------------------------------------------
// hmsc_csr
// Configuration registers: tick period and blink-on length.
// ----------------------------------------------------------------------------
module hmsc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [hmsc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hmsc_pkg::TickW-1:0]    csr_wdata,
   output hmsc_pkg::hmsc_cfg_type        cfg
);
   import hmsc_pkg::*;

   hmsc_cfg_type cfg_ff;
   hmsc_cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TICKS_PER_SEC: cfg_in.ticks_per_second = csr_wdata;
            CSR_BLINK_ON:      cfg_in.blink_on_ticks   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second <= TicksPerSecReset;
         cfg_ff.blink_on_ticks   <= BlinkOnReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // A tick period write lands in its register and leaves the blink length as it is
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == CSR_TICKS_PER_SEC |=>
         cfg_ff.ticks_per_second == $past(csr_wdata) && $stable(cfg_ff.blink_on_ticks))
      else $error("tick period write not applied");

endmodule

// File: sv/hmsc_core.sv
// ----------------------------------------------------------------------------
// hmsc_core
// Clock state and its update for each accepted request.
// ----------------------------------------------------------------------------
module hmsc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  hmsc_pkg::hmsc_req_type req,
   input  hmsc_pkg::hmsc_cfg_type cfg,
   output hmsc_pkg::hmsc_rsp_type rsp_next
);
   import hmsc_pkg::*;

   logic [HourW-1:0]   hour_ff,   hour_in;
   logic [MinW-1:0]    min_ff,    min_in;
   logic [SecW-1:0]    sec_ff,    sec_in;
   logic [TickW-1:0]   tick_ff,   tick_in;
   logic               edit_ff,   edit_in;
   logic [CursorW-1:0] cursor_ff, cursor_in;

   logic [TickW:0] tick_inc;
   logic [TickW:0] tps_ext;
   logic [SecW:0]  sec_inc;
   logic [MinW:0]  min_inc;
   logic [HourW:0] hour_inc;
   logic           key_ok;
   logic [3:0]     digit;

   assign tick_inc = {1'b0, tick_ff} + (TickW+1)'(1);
   assign tps_ext  = {1'b0, cfg.ticks_per_second};
   assign sec_inc  = {1'b0, sec_ff} + (SecW+1)'(1);
   assign min_inc  = {1'b0, min_ff} + (MinW+1)'(1);
   assign hour_inc = {1'b0, hour_ff} + (HourW+1)'(1);
   assign key_ok   = (req.key_code >= KeyDigitFirst) && (req.key_code <= KeyDigitLast);
   assign digit    = 4'(req.key_code - KeyDigitFirst);

   // Next state
   always_comb begin
      hour_in   = hour_ff;
      min_in    = min_ff;
      sec_in    = sec_ff;
      tick_in   = tick_ff;
      edit_in   = edit_ff;
      cursor_in = cursor_ff;
      unique case (cmd_type'(req.cmd))
         CMD_TICK: begin
            if (!edit_ff) begin
               if (tick_inc >= tps_ext) begin
                  // Roll the tick count and carry through seconds, minutes, hours
                  tick_in = '0;
                  if (sec_inc >= (SecW+1)'(MinLimit)) begin
                     sec_in = '0;
                     if (min_inc >= (MinW+1)'(MinLimit)) begin
                        min_in  = '0;
                        hour_in = (hour_inc >= (HourW+1)'(HourLimit)) ? '0
                                                                     : hour_inc[HourW-1:0];
                     end else begin
                        min_in = min_inc[MinW-1:0];
                     end
                  end else begin
                     sec_in = sec_inc[SecW-1:0];
                  end
               end else begin
                  tick_in = tick_inc[TickW-1:0];
               end
            end else begin
               // Blink counter only; time stays put
               tick_in = (tick_inc > tps_ext) ? '0 : tick_inc[TickW-1:0];
            end
         end
         CMD_MODE: edit_in = !edit_ff;
         CMD_NEXT: begin
            if (edit_ff) begin
               cursor_in = (cursor_ff >= CursorLast) ? '0 : cursor_ff + CursorW'(1);
            end
         end
         CMD_KEY: begin
            if (edit_ff && key_ok) begin
               unique case (cursor_type'(cursor_ff))
                  CUR_HOUR_TENS:
                     hour_in = HourW'(set_digit({1'b0, hour_ff}, digit, 1'b1, HourLimit));
                  CUR_HOUR_UNITS:
                     hour_in = HourW'(set_digit({1'b0, hour_ff}, digit, 1'b0, HourLimit));
                  CUR_MIN_TENS:   min_in = set_digit(min_ff, digit, 1'b1, MinLimit);
                  CUR_MIN_UNITS:  min_in = set_digit(min_ff, digit, 1'b0, MinLimit);
                  CUR_SEC_TENS:   sec_in = set_digit(sec_ff, digit, 1'b1, MinLimit);
                  default:        sec_in = set_digit(sec_ff, digit, 1'b0, MinLimit);
               endcase
            end
         end
         default: edit_in = edit_ff;
      endcase
   end

   // Advance state on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff   <= '0;
         min_ff    <= '0;
         sec_ff    <= '0;
         tick_ff   <= '0;
         edit_ff   <= 1'b0;
         cursor_ff <= '0;
      end else if (accept) begin
         hour_ff   <= hour_in;
         min_ff    <= min_in;
         sec_ff    <= sec_in;
         tick_ff   <= tick_in;
         edit_ff   <= edit_in;
         cursor_ff <= cursor_in;
      end
   end

   // Result reflects the updated state
   always_comb begin
      rsp_next.hours        = hour_in;
      rsp_next.minutes      = min_in;
      rsp_next.seconds      = sec_in;
      rsp_next.editing      = edit_in;
      rsp_next.cursor       = cursor_in;
      rsp_next.cursor_blank = edit_in && (tick_in != '0) && (tick_in <= cfg.blink_on_ticks);
   end

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff < HourW'(24) && min_ff < MinW'(60) && sec_ff < SecW'(60)
         && cursor_ff <= CursorLast)
      else $error("time or cursor out of range");

   a_mode_flip: assert property (@(posedge clock) disable iff (reset)
      accept && req.cmd == CMD_MODE |=> edit_ff != $past(edit_ff))
      else $error("mode request did not toggle edit mode");

   a_run_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !edit_ff && req.cmd != CMD_TICK && req.cmd != CMD_MODE |=>
         $stable(hour_ff) && $stable(min_ff) && $stable(sec_ff) && $stable(cursor_ff))
      else $error("edit request changed state in run mode");

endmodule

// File: sv/hmsc_rsp_reg.sv
// ----------------------------------------------------------------------------
// hmsc_rsp_reg
// Result register between the state update and the response channel.
// ----------------------------------------------------------------------------
module hmsc_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  hmsc_pkg::hmsc_rsp_type load_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hmsc_pkg::hmsc_rsp_type rsp_data,
   output logic                   room
);
   import hmsc_pkg::*;

   logic         valid_ff, valid_in;
   hmsc_rsp_type data_ff;

   // Room when empty or the held result leaves this cycle
   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && data_ff == $past(load_data))
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |-> !load)
      else $error("pending result overwritten");

endmodule

// File: sv/settable_hms_clock.sv
// ----------------------------------------------------------------------------
// settable_hms_clock
// 24-hour HH:MM:SS clock advanced by tick requests, with a set mode, digit
// cursor, digit key entry and cursor blink.
//
//   channel  ports              direction  payload
//   req      req_valid/ready    in         cmd, key_code
//   rsp      rsp_valid/ready    out        hours .. cursor_blank
//   csr      csr_wr_en          in         csr_index, csr_wdata (no wait)
//
// One request per cycle while the response side has room; the response is
// registered and shows in the next cycle, after a single combinational update.
// Reset is synchronous; it clears the time, mode, cursor and tick count and
// loads the register defaults. No clearing pass is needed.
// A stalled response holds the request side only while it cannot drain.
// ----------------------------------------------------------------------------
module settable_hms_clock (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  hmsc_pkg::hmsc_req_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hmsc_pkg::hmsc_rsp_type       rsp_data,
   input  logic                         csr_wr_en,
   input  logic [hmsc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [hmsc_pkg::TickW-1:0]   csr_wdata
);
   import hmsc_pkg::*;

   hmsc_cfg_type cfg;
   hmsc_rsp_type rsp_next;
   logic         room;
   logic         accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   hmsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hmsc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   hmsc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (rsp_next),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .room      (room)
   );

endmodule

// File: bench/tb_settable_hms_clock.sv
// ----------------------------------------------------------------------------
// tb_settable_hms_clock
// Self-checking bench for the settable HH:MM:SS clock. A directed table walks
// reset values, ignored commands, digit entry and cursor wrap. It is followed
// by randomized phases under several tick and blink settings: tick bursts,
// edit sessions, presets to just before midnight, and noise. Every response
// is checked against the table's typed-in value or a cycle-free model of the
// clock, with random request gaps and random response stalls.
// ----------------------------------------------------------------------------
module tb_settable_hms_clock;
   timeunit 1ns;
   timeprecision 1ps;

   import hmsc_pkg::*;

   typedef struct {
      cmd_type         cmd;
      logic [KeyW-1:0] key;
      bit              lit_on;
      hmsc_rsp_type    lit;
   } dir_row_type;

   typedef struct {
      logic [TickW-1:0] tps;
      logic [TickW-1:0] blink;
      bit               quiet;
      int               count;
   } setting_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_ready;
   hmsc_req_type         req_data   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready  = 1'b0;
   hmsc_rsp_type         rsp_data;
   logic                 csr_wr_en  = 1'b0;
   logic [CsrIdxW-1:0]   csr_index  = CSR_TICKS_PER_SEC;
   logic [TickW-1:0]     csr_wdata  = '0;

   // typed-in expectation that travels with the request it belongs to
   bit                   req_lit_on = 1'b0;
   hmsc_rsp_type         req_lit    = '0;

   // model state and settings
   logic [HourW-1:0]     now_h      = '0;
   logic [MinW-1:0]      now_m      = '0;
   logic [SecW-1:0]      now_s      = '0;
   logic [TickW-1:0]     now_tick   = '0;
   logic                 now_edit   = 1'b0;
   logic [CursorW-1:0]   now_cur    = CUR_HOUR_TENS;
   logic [TickW-1:0]     cfg_tps    = TicksPerSecReset;
   logic [TickW-1:0]     cfg_blink  = BlinkOnReset;

   hmsc_rsp_type         exp_display[$];

   // mode and cursor as the request stream sets them
   bit                   gen_edit   = 1'b0;
   int                   gen_cur    = 0;
   bit                   quiet      = 1'b0;

   int                   n_fail     = 0;
   int                   n_resp     = 0;
   int                   n_useful   = 0;
   int                   n_settings = 0;
   int                   n_midnight = 0;
   int                   n_blank    = 0;

   dir_row_type dir_rows [24] = '{
      '{CMD_TICK, 5'd0,  1'b1, '{5'd0,  6'd0,  6'd0,  1'b0, CUR_HOUR_TENS, 1'b0}},
      '{CMD_NEXT, 5'd0,  1'b1, '{5'd0,  6'd0,  6'd0,  1'b0, CUR_HOUR_TENS, 1'b0}},
      '{CMD_KEY,  5'd5,  1'b1, '{5'd0,  6'd0,  6'd0,  1'b0, CUR_HOUR_TENS, 1'b0}},
      '{CMD_MODE, 5'd31, 1'b1, '{5'd0,  6'd0,  6'd0,  1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_KEY,  5'd0,  1'b1, '{5'd0,  6'd0,  6'd0,  1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_KEY,  5'd11, 1'b1, '{5'd0,  6'd0,  6'd0,  1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_KEY,  5'd31, 1'b1, '{5'd0,  6'd0,  6'd0,  1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_KEY,  5'd3,  1'b1, '{5'd20, 6'd0,  6'd0,  1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_NEXT, 5'd31, 1'b0, '0},
      '{CMD_KEY,  5'd10, 1'b0, '0},
      '{CMD_KEY,  5'd4,  1'b0, '0},
      '{CMD_NEXT, 5'd0,  1'b0, '0},
      '{CMD_KEY,  5'd10, 1'b0, '0},
      '{CMD_KEY,  5'd6,  1'b0, '0},
      '{CMD_NEXT, 5'd0,  1'b0, '0},
      '{CMD_KEY,  5'd10, 1'b0, '0},
      '{CMD_NEXT, 5'd0,  1'b0, '0},
      '{CMD_KEY,  5'd6,  1'b0, '0},
      '{CMD_NEXT, 5'd0,  1'b0, '0},
      '{CMD_KEY,  5'd1,  1'b0, '0},
      '{CMD_NEXT, 5'd0,  1'b1, '{5'd23, 6'd59, 6'd50, 1'b1, CUR_HOUR_TENS, 1'b1}},
      '{CMD_TICK, 5'd0,  1'b0, '0},
      '{CMD_MODE, 5'd0,  1'b1, '{5'd23, 6'd59, 6'd50, 1'b0, CUR_HOUR_TENS, 1'b0}},
      '{CMD_TICK, 5'd0,  1'b0, '0}
   };

   setting_type settings [8] = '{
      '{12'd2,    12'd1,    1'b0, 300},
      '{12'd1,    12'd0,    1'b1, 150},
      '{12'd0,    12'd4095, 1'b0, 150},
      '{12'd4000, 12'd4000, 1'b0, 200},
      '{12'd2,    12'd4095, 1'b0, 300},
      '{12'd3,    12'd2,    1'b1, 150},
      '{12'd4095, 12'd0,    1'b0, 150},
      '{12'd5,    12'd3,    1'b0, 300}
   };

   settable_hms_clock u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Swap the tens or units digit of v; keep v when the result reaches limit
   function automatic logic [5:0] replace_digit(input logic [5:0] v, input int d,
                                                input bit tens, input int limit);
      int nv;
      nv = tens ? (int'(v) % 10) + d * 10 : (int'(v) / 10) * 10 + d;
      return (nv < limit) ? 6'(nv) : v;
   endfunction

   // Advance the clock model by one request and return the display it shows
   function automatic hmsc_rsp_type next_display(input hmsc_req_type r);
      logic [TickW:0] t;
      int             d;
      hmsc_rsp_type   o;
      t = {1'b0, now_tick} + 1'b1;
      case (cmd_type'(r.cmd))
         CMD_TICK: begin
            if (!now_edit) begin
               if (t >= {1'b0, cfg_tps}) begin
                  now_tick = '0;
                  if (now_s == 6'd59) begin
                     now_s = '0;
                     if (now_m == 6'd59) begin
                        now_m = '0;
                        if (now_h == 5'd23) begin
                           now_h = '0;
                           n_midnight++;
                        end else begin
                           now_h = now_h + 1'b1;
                        end
                     end else begin
                        now_m = now_m + 1'b1;
                     end
                  end else begin
                     now_s = now_s + 1'b1;
                  end
               end else begin
                  now_tick = t[TickW-1:0];
               end
            end else begin
               now_tick = (t > {1'b0, cfg_tps}) ? '0 : t[TickW-1:0];
            end
         end
         CMD_MODE: now_edit = ~now_edit;
         CMD_NEXT: begin
            if (now_edit) now_cur = (now_cur >= CUR_SEC_UNITS) ? CUR_HOUR_TENS : now_cur + 1'b1;
         end
         default: begin
            if (now_edit && r.key_code >= 5'd1 && r.key_code <= 5'd10) begin
               d = int'(r.key_code) - 1;
               case (now_cur)
                  CUR_HOUR_TENS:  now_h = 5'(replace_digit(6'(now_h), d, 1'b1, 24));
                  CUR_HOUR_UNITS: now_h = 5'(replace_digit(6'(now_h), d, 1'b0, 24));
                  CUR_MIN_TENS:   now_m = replace_digit(now_m, d, 1'b1, 60);
                  CUR_MIN_UNITS:  now_m = replace_digit(now_m, d, 1'b0, 60);
                  CUR_SEC_TENS:   now_s = replace_digit(now_s, d, 1'b1, 60);
                  default:        now_s = replace_digit(now_s, d, 1'b0, 60);
               endcase
            end
         end
      endcase
      o.hours        = now_h;
      o.minutes      = now_m;
      o.seconds      = now_s;
      o.editing      = now_edit;
      o.cursor       = now_cur;
      o.cursor_blank = now_edit && now_tick >= 12'd1 && now_tick <= cfg_blink;
      if (o.cursor_blank) n_blank++;
      return o;
   endfunction

   // Idle run length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request, hold it until accepted
   task automatic send_req(input cmd_type c, input logic [KeyW-1:0] k,
                           input bit lit_on = 1'b0, input hmsc_rsp_type lit = '0);
      int gap;
      gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data.cmd <= c;
      req_data.key_code <= k;
      req_lit_on   <= lit_on;
      req_lit      <= lit;
      // count requests that change something, track mode and cursor
      if (c == CMD_TICK || c == CMD_MODE || (gen_edit && c == CMD_NEXT)
          || (gen_edit && c == CMD_KEY && k >= 5'd1 && k <= 5'd10))
         n_useful++;
      if (c == CMD_MODE) gen_edit = !gen_edit;
      if (c == CMD_NEXT && gen_edit) gen_cur = (gen_cur >= 5) ? 0 : gen_cur + 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding response
   task automatic drain_display();
      req_valid <= 1'b0;
      @(posedge clock);
      while (exp_display.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [TickW-1:0] tps, input logic [TickW-1:0] blink);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TICKS_PER_SEC;
      csr_wdata <= tps;
      @(posedge clock);
      csr_index <= CSR_BLINK_ON;
      csr_wdata <= blink;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_tps   = tps;
      cfg_blink = blink;
      n_settings++;
   endtask

   task automatic goto_digit(input int target);
      while (gen_cur != target) send_req(CMD_NEXT, KeyW'($urandom_range(0, 31)));
   endtask

   // Set the time to 23:59:5x so the following ticks cross midnight
   task automatic preset_late();
      if (!gen_edit) send_req(CMD_MODE, '0);
      goto_digit(1);
      send_req(CMD_KEY, 5'd1);
      goto_digit(0);
      send_req(CMD_KEY, 5'd3);
      goto_digit(1);
      send_req(CMD_KEY, 5'd4);
      goto_digit(2);
      send_req(CMD_KEY, 5'd6);
      goto_digit(3);
      send_req(CMD_KEY, 5'd10);
      goto_digit(4);
      send_req(CMD_KEY, 5'd6);
      goto_digit(5);
      send_req(CMD_KEY, KeyW'($urandom_range(6, 10)));
      send_req(CMD_MODE, '0);
   endtask

   task automatic run_random(input int target);
      int start;
      int r;
      int k;
      start = n_useful;
      while (n_useful - start < target) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            // tick burst, in whichever mode the clock is
            repeat ($urandom_range(1, 30)) send_req(CMD_TICK, KeyW'($urandom_range(0, 31)));
         end else if (r < 70) begin
            // edit session with random digit entry
            if (!gen_edit) send_req(CMD_MODE, KeyW'($urandom_range(0, 31)));
            repeat ($urandom_range(2, 14)) begin
               k = $urandom_range(0, 99);
               if (k < 30)      send_req(CMD_NEXT, KeyW'($urandom_range(0, 31)));
               else if (k < 75) send_req(CMD_KEY, KeyW'($urandom_range(1, 10)));
               else if (k < 82) send_req(CMD_KEY, KeyW'($urandom_range(0, 31)));
               else             send_req(CMD_TICK, KeyW'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 3) != 0) send_req(CMD_MODE, '0);
         end else if (r < 80) begin
            preset_late();
         end else begin
            // noise
            repeat ($urandom_range(1, 4))
               send_req(cmd_type'($urandom_range(0, 3)), KeyW'($urandom_range(0, 31)));
         end
      end
   endtask

   // Response stalls: ready runs broken by idle stretches
   initial begin : rsp_stall
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20) stall_left = idle_len();
         end
      end
   end

   // Predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin : scoreboard
      hmsc_rsp_type want;
      hmsc_rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = next_display(req_data);
            exp_display.push_back(req_lit_on ? req_lit : want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            n_resp++;
            if (exp_display.size() == 0) begin
               $error("response with nothing expected: %h", got);
               n_fail++;
            end else begin
               want = exp_display.pop_front();
               if (got.hours != want.hours) begin
                  $error("hours: expected %0d, got %0d", want.hours, got.hours);
                  n_fail++;
               end
               if (got.minutes != want.minutes) begin
                  $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
                  n_fail++;
               end
               if (got.seconds != want.seconds) begin
                  $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
                  n_fail++;
               end
               if (got.editing != want.editing) begin
                  $error("editing: expected %0d, got %0d", want.editing, got.editing);
                  n_fail++;
               end
               if (got.cursor != want.cursor) begin
                  $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
                  n_fail++;
               end
               if (got.cursor_blank != want.cursor_blank) begin
                  $error("cursor_blank: expected %0d, got %0d",
                         want.cursor_blank, got.cursor_blank);
                  n_fail++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table under the register reset values
      foreach (dir_rows[i])
         send_req(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].lit_on, dir_rows[i].lit);
      drain_display();

      // random phases, one register setting each
      foreach (settings[p]) begin
         write_cfg(settings[p].tps, settings[p].blink);
         quiet = settings[p].quiet;
         run_random(settings[p].count);
         drain_display();
      end

      $display("Checked %0d responses from %0d effective requests over %0d settings.",
               n_resp, n_useful, n_settings);
      $display("Saw %0d midnight rollovers and %0d blanked-digit responses.",
               n_midnight, n_blank);
      if (n_fail == 0) begin
         $display("** settable_hms_clock: PASSED **");
      end else begin
         $display("** settable_hms_clock: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("timeout with %0d responses outstanding", exp_display.size());
      $display("** settable_hms_clock: FAILED **");
      $finish;
   end

endmodule

// File: files.f
sv/hmsc_pkg.sv
sv/hmsc_csr.sv
sv/hmsc_core.sv
sv/hmsc_rsp_reg.sv
sv/settable_hms_clock.sv
bench/tb_settable_hms_clock.sv
